[hdl/frl_pkg.sv]
package frl_pkg;

    localparam int          HDR_BYTES   = 12;
    localparam logic [31:0] REC_MAGIC   = 32'h4346_4721;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        OP_MOUNT       = 3'd0,
        OP_WRITE_BEGIN = 3'd1,
        OP_WRITE_DATA  = 3'd2,
        OP_READ_LATEST = 3'd3,
        OP_READ_DATA   = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NONE_FOUND = 3'd1,
        ST_BUF_SMALL  = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_NO_WRITE   = 3'd4,
        ST_BAD_OFFSET = 3'd5
    } t_status;

    // write data source for the flash image
    typedef enum logic {
        WS_ERASED,
        WS_BYTE
    } t_wsel;

    // controller to datapath commands
    typedef struct packed {
        logic  addr_load;
        logic  addr_inc;
        logic  mem_wr;
        t_wsel wsel;
        logic  hdr_cap;
        logic  xor_clr;
        logic  xor_acc;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic        rdata_erased;
        logic        magic_ok;
        logic [15:0] hdr_version;
        logic [15:0] hdr_length;
        logic        csum_ok;
    } t_dp_stat;

endpackage

[hdl/frl_if.sv]
interface frl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] record_version;
    logic [15:0] record_length;
    logic [7:0]  payload_byte;
    logic [15:0] reader_capacity;
    logic [9:0]  byte_offset;

    modport source (output valid, output opcode, output record_version, output record_length,
                    output payload_byte, output reader_capacity, output byte_offset,
                    input ready);
    modport sink   (input valid, input opcode, input record_version, input record_length,
                    input payload_byte, input reader_capacity, input byte_offset,
                    output ready);
endinterface

interface frl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] found_version;
    logic [9:0]  found_length;
    logic [7:0]  read_byte;
    logic [3:0]  unit_index;

    modport source (output valid, output status, output found_version, output found_length,
                    output read_byte, output unit_index, input ready);
    modport sink   (input valid, input status, input found_version, input found_length,
                    input read_byte, input unit_index, output ready);
endinterface

[hdl/frl_dp.sv]
module frl_dp #(
    parameter int STORE_BYTES = 16384,
    parameter int ADDR_W      = 14
) (
    input  logic              i_clk,
    input  frl_pkg::t_dp_cmd  i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [7:0]        i_wbyte,
    output logic [7:0]        o_rdata,
    output frl_pkg::t_dp_stat o_stat
);
    import frl_pkg::*;

    logic [7:0]             r_mem [STORE_BYTES];
    logic [ADDR_W-1:0]      r_addr;
    logic [7:0]             r_rdata;
    logic [7:0]             r_xor;
    logic [8*HDR_BYTES-1:0] r_hdr;
    logic [7:0]             w_wdata;

    // select erased fill or supplied byte
    assign w_wdata = (i_cmd.wsel == WS_ERASED) ? ERASED_BYTE : i_wbyte;

    // flash image: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // address walker, header capture and payload checksum
    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_load) begin
            r_addr <= i_addr;
        end else if (i_cmd.addr_inc) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_cmd.hdr_cap) begin
            r_hdr <= {r_rdata, r_hdr[8*HDR_BYTES-1:8]};
        end
        if (i_cmd.xor_clr) begin
            r_xor <= '0;
        end else if (i_cmd.xor_acc) begin
            r_xor <= r_xor ^ r_rdata;
        end
    end

    assign o_rdata             = r_rdata;
    assign o_stat.rdata_erased = (r_rdata == ERASED_BYTE);
    assign o_stat.magic_ok     = (r_hdr[31:0] == REC_MAGIC);
    assign o_stat.hdr_version  = r_hdr[47:32];
    assign o_stat.hdr_length   = r_hdr[63:48];
    assign o_stat.csum_ok      = (r_hdr[95:64] == {24'd0, r_xor});

endmodule

[hdl/frl_ctrl.sv]
module frl_ctrl #(
    parameter int STORE_BYTES  = 16384,
    parameter int SECTOR_BYTES = 4096,
    parameter int UNIT_BYTES   = 1024,
    parameter int ADDR_W       = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    frl_in_if.sink            i_req,
    frl_out_if.source         o_rsp,
    output frl_pkg::t_dp_cmd  o_cmd,
    output logic [ADDR_W-1:0] o_addr,
    output logic [7:0]        o_wbyte,
    input  logic [7:0]        i_rdata,
    input  frl_pkg::t_dp_stat i_stat
);
    import frl_pkg::*;

    localparam int UNIT_COUNT   = STORE_BYTES / UNIT_BYTES;
    localparam int SECTOR_COUNT = STORE_BYTES / SECTOR_BYTES;
    localparam int UPS          = SECTOR_BYTES / UNIT_BYTES;
    localparam int UNIT_W       = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int SEC_W        = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int SUB_W        = (UPS > 1) ? $clog2(UPS) : 1;
    localparam int LEN_W        = $clog2(UNIT_BYTES);
    localparam int MAX_PAYLOAD  = UNIT_BYTES - HDR_BYTES;

    localparam logic [ADDR_W-1:0] UNIT_SZ   = ADDR_W'(UNIT_BYTES);
    localparam logic [ADDR_W-1:0] SECTOR_SZ = ADDR_W'(SECTOR_BYTES);
    localparam logic [ADDR_W-1:0] HDR_OFS   = ADDR_W'(HDR_BYTES);
    localparam logic [ADDR_W-1:0] HDR_LAST  = ADDR_W'(HDR_BYTES - 1);
    localparam logic [ADDR_W-1:0] SEC_LAST  = ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_BYTES - 1);
    localparam logic [UNIT_W-1:0] UNIT_LAST = UNIT_W'(UNIT_COUNT - 1);
    localparam logic [SEC_W-1:0]  SEC_TOP   = SEC_W'(SECTOR_COUNT - 1);
    localparam logic [SUB_W-1:0]  SUB_LAST  = SUB_W'(UPS - 1);
    localparam logic [15:0]       MAX_LEN   = 16'(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        S_CLR_LOAD, S_CLR, S_IDLE, S_DECODE,
        S_MNT_LOAD, S_MNT_PRIME, S_MNT_SCAN,
        S_ERS_LOAD, S_ERS, S_BEGIN,
        S_HWR_LOAD, S_HWR, S_WD_WR,
        S_LAT_LOAD, S_LAT_PRIME, S_LAT_HDR, S_LAT_CHK, S_LAT_PPRIME, S_LAT_PAY, S_LAT_CSUM,
        S_RD_WAIT, S_RD_GET, S_DONE
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_cnt;
    // latched request
    logic [2:0]        r_op;
    logic [15:0]       r_ver;
    logic [15:0]       r_len;
    logic [7:0]        r_byte;
    logic [15:0]       r_cap;
    logic [9:0]        r_off;
    // log state
    logic [UNIT_W-1:0] r_next_unit;
    logic [SUB_W-1:0]  r_nsub;
    logic [SEC_W-1:0]  r_nsec;
    logic              r_wopen;
    logic [LEN_W-1:0]  r_plen;
    logic [15:0]       r_pver;
    logic [LEN_W-1:0]  r_bw;
    logic [7:0]        r_rxor;
    logic [UNIT_W-1:0] r_loc_unit;
    logic [LEN_W-1:0]  r_loc_len;
    logic              r_loc_valid;
    // scan bookkeeping
    logic [SEC_W-1:0]  r_sec_scan;
    logic [SEC_W-1:0]  r_ers_sec;
    logic              r_ret_begin;
    logic [UNIT_W-1:0] r_scan_u;
    logic [UNIT_W-1:0] r_ucnt;
    // working result
    t_status           r_st;
    logic [15:0]       r_fver;
    logic [9:0]        r_flen;
    logic [7:0]        r_rbyte;
    logic [3:0]        r_uidx;
    // output register
    logic              r_ovalid;
    t_status           r_o_st;
    logic [15:0]       r_o_fver;
    logic [9:0]        r_o_flen;
    logic [7:0]        r_o_rbyte;
    logic [3:0]        r_o_uidx;

    logic              w_wd_go;
    logic              w_rd_go;
    logic              w_hdr_ok;
    logic              w_last_unit;

    function automatic logic [ADDR_W-1:0] unit_base(input logic [UNIT_W-1:0] u);
        unit_base = ADDR_W'(u) * UNIT_SZ;
    endfunction

    function automatic logic [ADDR_W-1:0] sector_base(input logic [SEC_W-1:0] s);
        sector_base = ADDR_W'(s) * SECTOR_SZ;
    endfunction

    function automatic logic [UNIT_W-1:0] prev_unit(input logic [UNIT_W-1:0] u);
        prev_unit = (u == '0) ? UNIT_LAST : u - 1'b1;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] ver,
                                            input logic [15:0] len, input logic [7:0] x);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = REC_MAGIC[7:0];
            4'd1:    b = REC_MAGIC[15:8];
            4'd2:    b = REC_MAGIC[23:16];
            4'd3:    b = REC_MAGIC[31:24];
            4'd4:    b = ver[7:0];
            4'd5:    b = ver[15:8];
            4'd6:    b = len[7:0];
            4'd7:    b = len[15:8];
            4'd8:    b = x;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    assign w_wd_go     = (t_opcode'(r_op) == OP_WRITE_DATA) && r_wopen;
    assign w_rd_go     = (t_opcode'(r_op) == OP_READ_DATA) && r_loc_valid &&
                         (16'(r_off) < 16'(r_loc_len));
    assign w_hdr_ok    = i_stat.magic_ok && (i_stat.hdr_length != 16'd0) &&
                         (i_stat.hdr_length <= MAX_LEN);
    assign w_last_unit = (r_ucnt == UNIT_LAST);

    // datapath commands and addresses
    always_comb begin
        o_cmd      = '0;
        o_cmd.wsel = WS_BYTE;
        o_addr     = '0;
        o_wbyte    = r_byte;
        unique case (r_state)
            S_CLR_LOAD: o_cmd.addr_load = 1'b1;
            S_CLR, S_ERS: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wsel     = WS_ERASED;
                o_cmd.addr_inc = 1'b1;
            end
            S_DECODE: begin
                if (w_wd_go) begin
                    o_cmd.addr_load = 1'b1;
                    o_addr = unit_base(r_next_unit) + HDR_OFS + ADDR_W'(r_bw);
                end else if (w_rd_go) begin
                    o_cmd.addr_load = 1'b1;
                    o_addr = unit_base(r_loc_unit) + HDR_OFS + ADDR_W'(r_off);
                end
            end
            S_WD_WR: o_cmd.mem_wr = 1'b1;
            S_HWR_LOAD: begin
                o_cmd.addr_load = 1'b1;
                o_addr = unit_base(r_next_unit);
            end
            S_HWR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_inc = 1'b1;
                o_wbyte = hdr_byte(r_cnt[3:0], r_pver, 16'(r_plen), r_rxor);
            end
            S_MNT_LOAD: begin
                o_cmd.addr_load = 1'b1;
                o_addr = sector_base(r_sec_scan);
            end
            S_ERS_LOAD: begin
                o_cmd.addr_load = 1'b1;
                o_addr = sector_base(r_ers_sec);
            end
            S_LAT_LOAD: begin
                o_cmd.addr_load = 1'b1;
                o_cmd.xor_clr   = 1'b1;
                o_addr = unit_base(r_scan_u);
            end
            S_LAT_HDR: begin
                o_cmd.hdr_cap  = 1'b1;
                o_cmd.addr_inc = 1'b1;
            end
            S_LAT_CHK: begin
                o_cmd.addr_load = 1'b1;
                o_addr = unit_base(r_scan_u) + HDR_OFS;
            end
            S_LAT_PAY: begin
                o_cmd.xor_acc  = 1'b1;
                o_cmd.addr_inc = 1'b1;
            end
            S_MNT_PRIME, S_MNT_SCAN, S_LAT_PRIME, S_LAT_PPRIME: o_cmd.addr_inc = 1'b1;
            default: o_cmd.addr_inc = 1'b0;
        endcase
    end

    // sequencer, log state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_LOAD;
            r_next_unit <= '0;
            r_nsub      <= '0;
            r_nsec      <= '0;
            r_wopen     <= 1'b0;
            r_plen      <= '0;
            r_pver      <= '0;
            r_bw        <= '0;
            r_rxor      <= '0;
            r_loc_unit  <= '0;
            r_loc_len   <= '0;
            r_loc_valid <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // drop a taken result unless a new one is loaded this cycle
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                // sweep the whole image to erased after reset
                S_CLR_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_CLR;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STORE_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                // take a request and clear the working result
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.opcode;
                        r_ver   <= i_req.record_version;
                        r_len   <= i_req.record_length;
                        r_byte  <= i_req.payload_byte;
                        r_cap   <= i_req.reader_capacity;
                        r_off   <= i_req.byte_offset;
                        r_st    <= ST_OK;
                        r_fver  <= '0;
                        r_flen  <= '0;
                        r_rbyte <= '0;
                        r_uidx  <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    unique case (t_opcode'(r_op))
                        OP_MOUNT: begin
                            r_sec_scan <= '0;
                            r_wopen    <= 1'b0;
                            r_state    <= S_MNT_LOAD;
                        end
                        OP_WRITE_BEGIN: begin
                            if (r_len > MAX_LEN) begin
                                r_st    <= ST_TOO_LONG;
                                r_state <= S_DONE;
                            end else if (r_nsub == '0) begin
                                r_ers_sec   <= (r_nsec == SEC_TOP) ? '0 : r_nsec + 1'b1;
                                r_ret_begin <= 1'b1;
                                r_state     <= S_ERS_LOAD;
                            end else begin
                                r_state <= S_BEGIN;
                            end
                        end
                        OP_WRITE_DATA: begin
                            if (!r_wopen) begin
                                r_st    <= ST_NO_WRITE;
                                r_state <= S_DONE;
                            end else begin
                                r_uidx  <= 4'(r_next_unit);
                                r_state <= S_WD_WR;
                            end
                        end
                        OP_READ_LATEST: begin
                            r_loc_valid <= 1'b0;
                            r_st        <= ST_NONE_FOUND;
                            r_scan_u    <= prev_unit(r_next_unit);
                            r_ucnt      <= '0;
                            r_state     <= S_LAT_LOAD;
                        end
                        OP_READ_DATA: begin
                            if (!r_loc_valid) begin
                                r_st    <= ST_NONE_FOUND;
                                r_state <= S_DONE;
                            end else begin
                                r_flen <= 10'(r_loc_len);
                                r_uidx <= 4'(r_loc_unit);
                                if (w_rd_go) begin
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    r_st    <= ST_BAD_OFFSET;
                                    r_state <= S_DONE;
                                end
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                // look for the first blank sector
                S_MNT_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_MNT_PRIME;
                end
                S_MNT_PRIME: r_state <= S_MNT_SCAN;
                S_MNT_SCAN: begin
                    if (!i_stat.rdata_erased) begin
                        if (r_sec_scan == SEC_TOP) begin
                            r_ers_sec   <= '0;
                            r_ret_begin <= 1'b0;
                            r_state     <= S_ERS_LOAD;
                        end else begin
                            r_sec_scan <= r_sec_scan + 1'b1;
                            r_state    <= S_MNT_LOAD;
                        end
                    end else if (r_cnt == SEC_LAST) begin
                        r_next_unit <= UNIT_W'(UNIT_W'(r_sec_scan) * UNIT_W'(UPS));
                        r_uidx      <= 4'(UNIT_W'(UNIT_W'(r_sec_scan) * UNIT_W'(UPS)));
                        r_nsub      <= '0;
                        r_nsec      <= r_sec_scan;
                        r_state     <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // erase one sector
                S_ERS_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_ERS;
                end
                S_ERS: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SEC_LAST) begin
                        if (r_ret_begin) begin
                            r_state <= S_BEGIN;
                        end else begin
                            r_next_unit <= '0;
                            r_nsub      <= '0;
                            r_nsec      <= '0;
                            r_uidx      <= '0;
                            r_state     <= S_DONE;
                        end
                    end
                end
                // open a record
                S_BEGIN: begin
                    r_uidx  <= 4'(r_next_unit);
                    r_plen  <= LEN_W'(r_len);
                    r_pver  <= r_ver;
                    r_bw    <= '0;
                    r_rxor  <= '0;
                    r_wopen <= 1'b1;
                    r_state <= (r_len == 16'd0) ? S_HWR_LOAD : S_DONE;
                end
                // store one payload byte
                S_WD_WR: begin
                    r_rxor <= r_rxor ^ r_byte;
                    r_bw   <= r_bw + 1'b1;
                    r_state <= (LEN_W'(r_bw + 1'b1) == r_plen) ? S_HWR_LOAD : S_DONE;
                end
                // write the header and advance the ring
                S_HWR_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_HWR;
                end
                S_HWR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == HDR_LAST) begin
                        r_wopen <= 1'b0;
                        if (r_next_unit == UNIT_LAST) begin
                            r_next_unit <= '0;
                            r_nsub      <= '0;
                            r_nsec      <= '0;
                        end else begin
                            r_next_unit <= r_next_unit + 1'b1;
                            if (r_nsub == SUB_LAST) begin
                                r_nsub <= '0;
                                r_nsec <= (r_nsec == SEC_TOP) ? '0 : r_nsec + 1'b1;
                            end else begin
                                r_nsub <= r_nsub + 1'b1;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                // walk back through units for a valid record
                S_LAT_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_LAT_PRIME;
                end
                S_LAT_PRIME: r_state <= S_LAT_HDR;
                S_LAT_HDR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == HDR_LAST) begin
                        r_state <= S_LAT_CHK;
                    end
                end
                S_LAT_CHK: begin
                    r_cnt <= '0;
                    if (w_hdr_ok) begin
                        r_state <= S_LAT_PPRIME;
                    end else if (w_last_unit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_scan_u <= prev_unit(r_scan_u);
                        r_ucnt   <= r_ucnt + 1'b1;
                        r_state  <= S_LAT_LOAD;
                    end
                end
                S_LAT_PPRIME: r_state <= S_LAT_PAY;
                S_LAT_PAY: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ADDR_W'(i_stat.hdr_length - 16'd1)) begin
                        r_state <= S_LAT_CSUM;
                    end
                end
                S_LAT_CSUM: begin
                    if (i_stat.csum_ok) begin
                        r_fver <= i_stat.hdr_version;
                        r_flen <= i_stat.hdr_length[9:0];
                        r_uidx <= 4'(r_scan_u);
                        if (i_stat.hdr_length > r_cap) begin
                            r_st <= ST_BUF_SMALL;
                        end else begin
                            r_st        <= ST_OK;
                            r_loc_unit  <= r_scan_u;
                            r_loc_len   <= LEN_W'(i_stat.hdr_length);
                            r_loc_valid <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (w_last_unit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_scan_u <= prev_unit(r_scan_u);
                        r_ucnt   <= r_ucnt + 1'b1;
                        r_state  <= S_LAT_LOAD;
                    end
                end
                // fetch one payload byte
                S_RD_WAIT: r_state <= S_RD_GET;
                S_RD_GET: begin
                    r_rbyte <= i_rdata;
                    r_state <= S_DONE;
                end
                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_o_st    <= r_st;
                        r_o_fver  <= r_fver;
                        r_o_flen  <= r_flen;
                        r_o_rbyte <= r_rbyte;
                        r_o_uidx  <= r_uidx;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_o_st;
    assign o_rsp.found_version = r_o_fver;
    assign o_rsp.found_length  = r_o_flen;
    assign o_rsp.read_byte     = r_o_rbyte;
    assign o_rsp.unit_index    = r_o_uidx;

endmodule

[hdl/flash_ring_record_log.sv]
// Record log kept in a ring of flash units, one record per unit.
// i_req carries one request (mount, write_begin, write_data, read_latest,
// read_data); o_rsp returns exactly one result for each request, in order.
// Requests are taken one at a time; i_req.ready is high only when idle.
// The flash image has a single byte-wide port, so each request walks it a byte
// at a time: write_data stores one byte and, when it closes the record, writes
// the 12 header bytes; write_begin erases the sector ahead first when the record
// opens a sector, and writes the header at once for a zero-length record;
// read_data fetches one byte; refused requests touch no flash; mount scans the
// sectors for the first blank one; read_latest walks back through the units
// for a valid record. After reset the image is swept to 0xFF, one byte a cycle;
// no request is taken until it ends.
// A result waits in the output register while o_rsp.ready is low; the next
// request is still taken, and its result is held back until the first
// has been taken.
module flash_ring_record_log #(
    parameter int STORE_BYTES  = 16384,
    parameter int SECTOR_BYTES = 4096,
    parameter int UNIT_BYTES   = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frl_in_if.sink    i_req,
    frl_out_if.source o_rsp
);
    import frl_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_wbyte;
    logic [7:0]        w_rdata;

    frl_ctrl #(
        .STORE_BYTES  (STORE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .UNIT_BYTES   (UNIT_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_cmd   (w_cmd),
        .o_addr  (w_addr),
        .o_wbyte (w_wbyte),
        .i_rdata (w_rdata),
        .i_stat  (w_stat)
    );

    frl_dp #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .i_wbyte (w_wbyte),
        .o_rdata (w_rdata),
        .o_stat  (w_stat)
    );

    // no flash write while a request can be taken
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_wr |-> !i_req.ready)
        else $error("flash write while idle");

    // reset empties the output and blocks requests during the sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid && !i_req.ready)
        else $error("output or ready active after reset");

    // a taken request keeps the block busy next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("second request taken back to back");

    // only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.status <= ST_BAD_OFFSET)
        else $error("undefined status code");

endmodule
